[sv/gn2d_pkg.sv]
// gn2d_pkg: shared widths, fade curve constants and codes for the 2-D gradient noise core.
// No dependencies; every other file of the core imports it.
`timescale 1ns / 1ps

package gn2d_pkg;

  localparam int unsigned COORD_W         = 24;  // unsigned fixed-point coordinate
  localparam int unsigned ENTRY_W         = 8;   // permutation entry index and value
  localparam int unsigned FRAC_BITS_DEF   = 16;
  localparam int unsigned TABLE_DEPTH_DEF = 256;
  localparam int unsigned QUEUE_DEPTH     = 4;   // power of two

  // quintic fade 6t^5 - 15t^4 + 10t^3 = t^3 * (10 - t*(15 - 6t))
  localparam int unsigned FADE_K6  = 6;
  localparam int unsigned FADE_K15 = 15;
  localparam int unsigned FADE_K10 = 10;

  typedef enum logic {
    KIND_LOAD   = 1'b0,
    KIND_SAMPLE = 1'b1
  } kind_e;

  // low three hash bits select the corner gradient
  typedef enum logic [2:0] {
    GRAD_PX_PY = 3'd0,
    GRAD_PX_NY = 3'd1,
    GRAD_NX_PY = 3'd2,
    GRAD_NX_NY = 3'd3,
    GRAD_PX    = 3'd4,
    GRAD_NX    = 3'd5,
    GRAD_PY    = 3'd6,
    GRAD_NY    = 3'd7
  } grad_e;

endpackage

[sv/gn2d_front.sv]
// gn2d_front: input register that accepts items and decodes them into table loads
// or sample cells (wrapped integer corners plus fractions). Depends on gn2d_pkg.
`timescale 1ns / 1ps

module gn2d_front #(
  parameter int unsigned FRAC_BITS   = gn2d_pkg::FRAC_BITS_DEF,
  parameter int unsigned TABLE_DEPTH = gn2d_pkg::TABLE_DEPTH_DEF,
  localparam int unsigned IDX_W      = $clog2(TABLE_DEPTH)
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  logic                         kind_i,
  input  logic [gn2d_pkg::ENTRY_W-1:0] entry_index_i,
  input  logic [gn2d_pkg::ENTRY_W-1:0] entry_value_i,
  input  logic [gn2d_pkg::COORD_W-1:0] coord_x_i,
  input  logic [gn2d_pkg::COORD_W-1:0] coord_y_i,
  output logic                         push_valid_o,
  input  logic                         queue_full_i,
  output logic                         is_load_o,
  output logic [IDX_W-1:0]             ix0_o,   // table index for a load, x corner for a sample
  output logic [IDX_W-1:0]             ix1_o,
  output logic [IDX_W-1:0]             iy0_o,
  output logic [IDX_W-1:0]             iy1_o,
  output logic [FRAC_BITS-1:0]         fx_o,
  output logic [FRAC_BITS-1:0]         fy_o,
  output logic [gn2d_pkg::ENTRY_W-1:0] value_o
);
  import gn2d_pkg::*;

  localparam logic [IDX_W-1:0] IDX_MASK = IDX_W'(TABLE_DEPTH - 1);
  localparam int unsigned      XW       = COORD_W + IDX_W;

  logic                 accept;
  logic [XW-1:0]        x_int, y_int, e_ext;
  logic [IDX_W-1:0]     ix0_c, iy0_c, idx_c;
  logic                 valid_q;
  logic                 load_d, load_q;
  logic [IDX_W-1:0]     ix0_d, ix1_d, iy0_d, iy1_d;
  logic [IDX_W-1:0]     ix0_q, ix1_q, iy0_q, iy1_q;
  logic [FRAC_BITS-1:0] fx_q, fy_q;
  logic [ENTRY_W-1:0]   value_q;

  assign in_stall_o = valid_q & queue_full_i;
  assign accept     = in_valid_i & ~in_stall_o;

  always_comb begin
    x_int  = XW'(coord_x_i) >> FRAC_BITS;
    y_int  = XW'(coord_y_i) >> FRAC_BITS;
    e_ext  = XW'(entry_index_i);
    ix0_c  = x_int[IDX_W-1:0] & IDX_MASK;
    iy0_c  = y_int[IDX_W-1:0] & IDX_MASK;
    idx_c  = e_ext[IDX_W-1:0] & IDX_MASK;
    load_d = (kind_e'(kind_i) == KIND_LOAD);
    ix0_d  = load_d ? idx_c : ix0_c;
    ix1_d  = (ix0_c + 1'b1) & IDX_MASK;
    iy0_d  = iy0_c;
    iy1_d  = (iy0_c + 1'b1) & IDX_MASK;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (!in_stall_o) begin
      valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      load_q  <= load_d;
      ix0_q   <= ix0_d;
      ix1_q   <= ix1_d;
      iy0_q   <= iy0_d;
      iy1_q   <= iy1_d;
      fx_q    <= coord_x_i[FRAC_BITS-1:0];
      fy_q    <= coord_y_i[FRAC_BITS-1:0];
      value_q <= entry_value_i;
    end
  end

  assign push_valid_o = valid_q;
  assign is_load_o    = load_q;
  assign ix0_o        = ix0_q;
  assign ix1_o        = ix1_q;
  assign iy0_o        = iy0_q;
  assign iy1_o        = iy1_q;
  assign fx_o         = fx_q;
  assign fy_o         = fy_q;
  assign value_o      = value_q;

endmodule

[sv/gn2d_queue.sv]
// gn2d_queue: short FIFO of decoded items between the front and back parts.
// Depends on gn2d_pkg (depth and entry width).
`timescale 1ns / 1ps

module gn2d_queue #(
  parameter int unsigned FRAC_BITS   = gn2d_pkg::FRAC_BITS_DEF,
  parameter int unsigned TABLE_DEPTH = gn2d_pkg::TABLE_DEPTH_DEF,
  localparam int unsigned IDX_W      = $clog2(TABLE_DEPTH)
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         push_i,
  output logic                         full_o,
  input  logic                         load_i,
  input  logic [IDX_W-1:0]             ix0_i,
  input  logic [IDX_W-1:0]             ix1_i,
  input  logic [IDX_W-1:0]             iy0_i,
  input  logic [IDX_W-1:0]             iy1_i,
  input  logic [FRAC_BITS-1:0]         fx_i,
  input  logic [FRAC_BITS-1:0]         fy_i,
  input  logic [gn2d_pkg::ENTRY_W-1:0] value_i,
  input  logic                         pop_i,
  output logic                         empty_o,
  output logic                         load_o,
  output logic [IDX_W-1:0]             ix0_o,
  output logic [IDX_W-1:0]             ix1_o,
  output logic [IDX_W-1:0]             iy0_o,
  output logic [IDX_W-1:0]             iy1_o,
  output logic [FRAC_BITS-1:0]         fx_o,
  output logic [FRAC_BITS-1:0]         fy_o,
  output logic [gn2d_pkg::ENTRY_W-1:0] value_o
);
  import gn2d_pkg::*;

  localparam int unsigned      PTR_W   = $clog2(QUEUE_DEPTH);
  localparam logic [PTR_W:0]   DEPTH_C = (PTR_W + 1)'(QUEUE_DEPTH);

  logic                 do_push, do_pop;
  logic [PTR_W-1:0]     wr_ptr_q, rd_ptr_q;
  logic [PTR_W:0]       count_q, count_d;
  logic                 load_s  [QUEUE_DEPTH];
  logic [IDX_W-1:0]     ix0_s   [QUEUE_DEPTH];
  logic [IDX_W-1:0]     ix1_s   [QUEUE_DEPTH];
  logic [IDX_W-1:0]     iy0_s   [QUEUE_DEPTH];
  logic [IDX_W-1:0]     iy1_s   [QUEUE_DEPTH];
  logic [FRAC_BITS-1:0] fx_s    [QUEUE_DEPTH];
  logic [FRAC_BITS-1:0] fy_s    [QUEUE_DEPTH];
  logic [ENTRY_W-1:0]   value_s [QUEUE_DEPTH];

  assign full_o  = (count_q == DEPTH_C);
  assign empty_o = (count_q == '0);
  assign do_push = push_i & ~full_o;
  assign do_pop  = pop_i & ~empty_o;

  always_comb begin
    unique case ({do_push, do_pop})
      2'b10:   count_d = count_q + 1'b1;
      2'b01:   count_d = count_q - 1'b1;
      default: count_d = count_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      count_q <= count_d;
      if (do_push) wr_ptr_q <= wr_ptr_q + 1'b1;
      if (do_pop)  rd_ptr_q <= rd_ptr_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      load_s[wr_ptr_q]  <= load_i;
      ix0_s[wr_ptr_q]   <= ix0_i;
      ix1_s[wr_ptr_q]   <= ix1_i;
      iy0_s[wr_ptr_q]   <= iy0_i;
      iy1_s[wr_ptr_q]   <= iy1_i;
      fx_s[wr_ptr_q]    <= fx_i;
      fy_s[wr_ptr_q]    <= fy_i;
      value_s[wr_ptr_q] <= value_i;
    end
  end

  assign load_o  = load_s[rd_ptr_q];
  assign ix0_o   = ix0_s[rd_ptr_q];
  assign ix1_o   = ix1_s[rd_ptr_q];
  assign iy0_o   = iy0_s[rd_ptr_q];
  assign iy1_o   = iy1_s[rd_ptr_q];
  assign fx_o    = fx_s[rd_ptr_q];
  assign fy_o    = fy_s[rd_ptr_q];
  assign value_o = value_s[rd_ptr_q];

endmodule

[sv/gn2d_back.sv]
// gn2d_back: permutation table copies, hash lookups, fade curves, corner gradients
// and the three lerps, as an eight-stage pipeline ending in the output register.
// Depends on gn2d_pkg.
`timescale 1ns / 1ps

module gn2d_back #(
  parameter int unsigned FRAC_BITS   = gn2d_pkg::FRAC_BITS_DEF,
  parameter int unsigned TABLE_DEPTH = gn2d_pkg::TABLE_DEPTH_DEF,
  localparam int unsigned IDX_W      = $clog2(TABLE_DEPTH)
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         empty_i,
  output logic                         pop_o,
  input  logic                         head_load_i,
  input  logic [IDX_W-1:0]             head_ix0_i,
  input  logic [IDX_W-1:0]             head_ix1_i,
  input  logic [IDX_W-1:0]             head_iy0_i,
  input  logic [IDX_W-1:0]             head_iy1_i,
  input  logic [FRAC_BITS-1:0]         head_fx_i,
  input  logic [FRAC_BITS-1:0]         head_fy_i,
  input  logic [gn2d_pkg::ENTRY_W-1:0] head_value_i,
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output logic signed [FRAC_BITS+1:0]  noise_value_o
);
  import gn2d_pkg::*;

  localparam int unsigned F     = FRAC_BITS;
  localparam int unsigned KW    = F + 4;        // fade polynomial terms
  localparam int unsigned SQW   = 2 * F;
  localparam int unsigned PMW   = F + KW;
  localparam int unsigned GW    = F + 3;        // corner dot products, lerp results
  localparam int unsigned DW    = F + 4;        // lerp differences
  localparam int unsigned PW    = F + 1 + DW;   // lerp products
  localparam int unsigned OW    = F + 2;
  localparam int unsigned SW    = (IDX_W > ENTRY_W) ? IDX_W : ENTRY_W;
  localparam int unsigned NSTG  = 7;

  localparam logic [IDX_W-1:0]     IDX_MASK = IDX_W'(TABLE_DEPTH - 1);
  localparam logic [KW-1:0]        K15      = KW'(FADE_K15) << F;
  localparam logic [KW-1:0]        K10      = KW'(FADE_K10) << F;
  localparam logic [F-1:0]         FADE_MAX = '1;
  localparam logic signed [GW-1:0] ONE_S    = GW'(1) << F;
  localparam logic signed [PW-1:0] R_MAX    = (PW'(1) << (F + 1)) - 1;
  localparam logic signed [PW-1:0] R_MIN    = -(PW'(1) << (F + 1));

  function automatic logic [IDX_W-1:0] hash_addr(input logic [ENTRY_W-1:0] p,
                                                 input logic [IDX_W-1:0] iy);
    logic [SW-1:0] s;
    s = SW'(p) + SW'(iy);
    return s[IDX_W-1:0] & IDX_MASK;
  endfunction

  function automatic logic signed [GW-1:0] grad_dot(input logic [2:0] h,
                                                    input logic signed [GW-1:0] dx,
                                                    input logic signed [GW-1:0] dy);
    logic signed [GW-1:0] r;
    unique case (grad_e'(h))
      GRAD_PX_PY: r = dx + dy;
      GRAD_PX_NY: r = dx - dy;
      GRAD_NX_PY: r = dy - dx;
      GRAD_NX_NY: r = -dx - dy;
      GRAD_PX:    r = dx;
      GRAD_NX:    r = -dx;
      GRAD_PY:    r = dy;
      GRAD_NY:    r = -dy;
    endcase
    return r;
  endfunction

  // whole pipeline advances together; frozen only while a result waits
  logic en, we;
  logic [NSTG-1:0] vld_q;
  logic            out_valid_q;

  assign en    = ~(out_valid_q & out_stall_i);
  assign pop_o = en & ~empty_i;
  assign we    = pop_o & head_load_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q       <= '0;
      out_valid_q <= 1'b0;
    end else if (en) begin
      vld_q       <= {vld_q[NSTG-2:0], pop_o & ~head_load_i};
      out_valid_q <= vld_q[NSTG-1];
    end
  end

  // three table copies: A resolves perm[ix], B and C the two corner columns
  logic [ENTRY_W-1:0] mem_a [TABLE_DEPTH];
  logic [ENTRY_W-1:0] mem_b [TABLE_DEPTH];
  logic [ENTRY_W-1:0] mem_c [TABLE_DEPTH];

  // stage 1
  logic [ENTRY_W-1:0]   pa0_q, pa1_q;
  logic [IDX_W-1:0]     iy0_1_q, iy1_1_q;
  logic [FRAC_BITS-1:0] f1_q [2];

  always_ff @(posedge clk_i) begin
    if (we) mem_a[head_ix0_i] <= head_value_i;
    if (en) begin
      pa0_q <= mem_a[head_ix0_i];
      pa1_q <= mem_a[head_ix1_i];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      iy0_1_q <= head_iy0_i;
      iy1_1_q <= head_iy1_i;
      f1_q[0] <= head_fx_i;
      f1_q[1] <= head_fy_i;
    end
  end

  // stage 2: corner hashes and first fade step
  logic [IDX_W-1:0]   addr_b0, addr_b1, addr_c0, addr_c1;
  logic [ENTRY_W-1:0] h00_q, h01_q, h10_q, h11_q;
  logic [SQW-1:0]     sq_c   [2];
  logic [KW-1:0]      poly_c [2];
  logic [PMW-1:0]     pm_c   [2];
  logic [KW-1:0]      inner_c[2];
  logic [F-1:0]       t2_q   [2];
  logic [KW-1:0]      inner_q[2];
  logic [F-1:0]       f2_q   [2];

  assign addr_b0 = hash_addr(pa0_q, iy0_1_q);
  assign addr_b1 = hash_addr(pa0_q, iy1_1_q);
  assign addr_c0 = hash_addr(pa1_q, iy0_1_q);
  assign addr_c1 = hash_addr(pa1_q, iy1_1_q);

  always_ff @(posedge clk_i) begin
    if (we) mem_b[head_ix0_i] <= head_value_i;
    if (en) begin
      h00_q <= mem_b[addr_b0];
      h01_q <= mem_b[addr_b1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (we) mem_c[head_ix0_i] <= head_value_i;
    if (en) begin
      h10_q <= mem_c[addr_c0];
      h11_q <= mem_c[addr_c1];
    end
  end

  always_comb begin
    for (int k = 0; k < 2; k++) begin
      sq_c[k]    = SQW'(f1_q[k]) * SQW'(f1_q[k]);
      poly_c[k]  = K15 - KW'(KW'(f1_q[k]) * KW'(FADE_K6));
      pm_c[k]    = PMW'(f1_q[k]) * PMW'(poly_c[k]);
      inner_c[k] = K10 - pm_c[k][PMW-1:F];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int k = 0; k < 2; k++) begin
        t2_q[k]    <= sq_c[k][SQW-1:F];
        inner_q[k] <= inner_c[k];
        f2_q[k]    <= f1_q[k];
      end
    end
  end

  // stage 3: t^3 and the four corner dot products
  logic [SQW-1:0]       t3p_c  [2];
  logic [F-1:0]         t3_q   [2];
  logic [KW-1:0]        inner3_q[2];
  logic signed [GW-1:0] dx0, dy0, dx1, dy1;
  logic signed [GW-1:0] g3_q   [4];   // g00, g10, g01, g11

  always_comb begin
    for (int k = 0; k < 2; k++) begin
      t3p_c[k] = SQW'(t2_q[k]) * SQW'(f2_q[k]);
    end
    dx0 = $signed(GW'(f2_q[0]));
    dy0 = $signed(GW'(f2_q[1]));
    dx1 = dx0 - ONE_S;
    dy1 = dy0 - ONE_S;
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int k = 0; k < 2; k++) begin
        t3_q[k]     <= t3p_c[k][SQW-1:F];
        inner3_q[k] <= inner_q[k];
      end
      g3_q[0] <= grad_dot(h00_q[2:0], dx0, dy0);
      g3_q[1] <= grad_dot(h10_q[2:0], dx1, dy0);
      g3_q[2] <= grad_dot(h01_q[2:0], dx0, dy1);
      g3_q[3] <= grad_dot(h11_q[2:0], dx1, dy1);
    end
  end

  // stage 4: fade = t^3 * inner, clipped just below one
  logic [PMW-1:0]       fp_c [2];
  logic [KW-1:0]        fd_c [2];
  logic [F-1:0]         fade_q [2];
  logic signed [GW-1:0] g4_q [4];

  always_comb begin
    for (int k = 0; k < 2; k++) begin
      fp_c[k] = PMW'(t3_q[k]) * PMW'(inner3_q[k]);
      fd_c[k] = fp_c[k][PMW-1:F];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int k = 0; k < 2; k++) begin
        fade_q[k] <= (fd_c[k] > KW'(FADE_MAX)) ? FADE_MAX : fd_c[k][F-1:0];
      end
      for (int k = 0; k < 4; k++) begin
        g4_q[k] <= g3_q[k];
      end
    end
  end

  // stage 5: x-direction lerp products
  logic signed [DW-1:0] dlo_c, dhi_c;
  logic signed [PW-1:0] ux_c;
  logic signed [PW-1:0] pr5_q [2];
  logic signed [GW-1:0] ga5_q [2];
  logic [F-1:0]         fv5_q;

  always_comb begin
    dlo_c = DW'(g4_q[1]) - DW'(g4_q[0]);
    dhi_c = DW'(g4_q[3]) - DW'(g4_q[2]);
    ux_c  = PW'($signed({1'b0, fade_q[0]}));
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      pr5_q[0] <= ux_c * PW'(dlo_c);
      pr5_q[1] <= ux_c * PW'(dhi_c);
      ga5_q[0] <= g4_q[0];
      ga5_q[1] <= g4_q[2];
      fv5_q    <= fade_q[1];
    end
  end

  // stage 6: x-direction lerp sums (arithmetic shift floors)
  logic signed [PW-1:0] xs_c [2];
  logic signed [GW-1:0] x6_q [2];
  logic [F-1:0]         fv6_q;

  always_comb begin
    for (int k = 0; k < 2; k++) begin
      xs_c[k] = PW'(ga5_q[k]) + (pr5_q[k] >>> F);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      x6_q[0] <= xs_c[0][GW-1:0];
      x6_q[1] <= xs_c[1][GW-1:0];
      fv6_q   <= fv5_q;
    end
  end

  // stage 7: y-direction lerp product
  logic signed [DW-1:0] dy_c;
  logic signed [PW-1:0] pr7_q;
  logic signed [GW-1:0] x7_q;

  assign dy_c = DW'(x6_q[1]) - DW'(x6_q[0]);

  always_ff @(posedge clk_i) begin
    if (en) begin
      pr7_q <= PW'($signed({1'b0, fv6_q})) * PW'(dy_c);
      x7_q  <= x6_q[0];
    end
  end

  // output register: final sum, saturated to Q2.F
  logic signed [PW-1:0] r_c;
  logic signed [PW-1:0] rs_c;
  logic signed [OW-1:0] noise_q;

  always_comb begin
    r_c = PW'(x7_q) + (pr7_q >>> F);
    priority if (r_c > R_MAX) begin
      rs_c = R_MAX;
    end else if (r_c < R_MIN) begin
      rs_c = R_MIN;
    end else begin
      rs_c = r_c;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) noise_q <= rs_c[OW-1:0];
  end

  assign out_valid_o   = out_valid_q;
  assign noise_value_o = noise_q;

endmodule

[sv/gradient_noise_2d_core.sv]
// gradient_noise_2d_core: top level of the 2-D gradient noise core (front decode,
// item queue, back pipeline). Depends on gn2d_pkg, gn2d_front, gn2d_queue, gn2d_back.
`timescale 1ns / 1ps

//  channel | direction | handshake                | payload
//  --------+-----------+--------------------------+------------------------------------
//  in      | input     | in_valid_i / in_stall_o  | kind, entry_index, entry_value,
//          |           |                          | coord_x, coord_y
//  out     | output    | out_valid_o / out_stall_i| noise_value (signed Q2.FRAC_BITS)
//
//  One item per cycle sustained while no result waits on out_stall_i. A sample item
//  passes the front register, the queue and the seven back stages, and the output
//  register then drives out_valid_o. A load item writes the table and produces no
//  result. Reset clears only the control state; table contents are undefined until
//  loaded. While out_stall_i holds a result, the back pipeline freezes, and the input
//  keeps being taken until the four-entry queue and the front register are full.

module gradient_noise_2d_core #(
  parameter int unsigned FRAC_BITS   = gn2d_pkg::FRAC_BITS_DEF,
  parameter int unsigned TABLE_DEPTH = gn2d_pkg::TABLE_DEPTH_DEF
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  logic                         kind_i,
  input  logic [gn2d_pkg::ENTRY_W-1:0] entry_index_i,
  input  logic [gn2d_pkg::ENTRY_W-1:0] entry_value_i,
  input  logic [gn2d_pkg::COORD_W-1:0] coord_x_i,
  input  logic [gn2d_pkg::COORD_W-1:0] coord_y_i,
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output logic signed [FRAC_BITS+1:0]  noise_value_o
);
  import gn2d_pkg::*;

  localparam int unsigned IDX_W = $clog2(TABLE_DEPTH);

  // front -> queue
  logic                 q_push, q_full;
  logic                 f_load;
  logic [IDX_W-1:0]     f_ix0, f_ix1, f_iy0, f_iy1;
  logic [FRAC_BITS-1:0] f_fx, f_fy;
  logic [ENTRY_W-1:0]   f_value;

  // queue -> back
  logic                 q_pop, q_empty;
  logic                 h_load;
  logic [IDX_W-1:0]     h_ix0, h_ix1, h_iy0, h_iy1;
  logic [FRAC_BITS-1:0] h_fx, h_fy;
  logic [ENTRY_W-1:0]   h_value;

  // accepts items and splits them into table loads and decoded sample cells
  gn2d_front #(
    .FRAC_BITS   (FRAC_BITS),
    .TABLE_DEPTH (TABLE_DEPTH)
  ) u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .kind_i        (kind_i),
    .entry_index_i (entry_index_i),
    .entry_value_i (entry_value_i),
    .coord_x_i     (coord_x_i),
    .coord_y_i     (coord_y_i),
    .push_valid_o  (q_push),
    .queue_full_i  (q_full),
    .is_load_o     (f_load),
    .ix0_o         (f_ix0),
    .ix1_o         (f_ix1),
    .iy0_o         (f_iy0),
    .iy1_o         (f_iy1),
    .fx_o          (f_fx),
    .fy_o          (f_fy),
    .value_o       (f_value)
  );

  // decouples the input side from the stallable result pipeline
  gn2d_queue #(
    .FRAC_BITS   (FRAC_BITS),
    .TABLE_DEPTH (TABLE_DEPTH)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .full_o  (q_full),
    .load_i  (f_load),
    .ix0_i   (f_ix0),
    .ix1_i   (f_ix1),
    .iy0_i   (f_iy0),
    .iy1_i   (f_iy1),
    .fx_i    (f_fx),
    .fy_i    (f_fy),
    .value_i (f_value),
    .pop_i   (q_pop),
    .empty_o (q_empty),
    .load_o  (h_load),
    .ix0_o   (h_ix0),
    .ix1_o   (h_ix1),
    .iy0_o   (h_iy0),
    .iy1_o   (h_iy1),
    .fx_o    (h_fx),
    .fy_o    (h_fy),
    .value_o (h_value)
  );

  // table writes happen as a load leaves the queue, in order with the samples' reads
  gn2d_back #(
    .FRAC_BITS   (FRAC_BITS),
    .TABLE_DEPTH (TABLE_DEPTH)
  ) u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .empty_i       (q_empty),
    .pop_o         (q_pop),
    .head_load_i   (h_load),
    .head_ix0_i    (h_ix0),
    .head_ix1_i    (h_ix1),
    .head_iy0_i    (h_iy0),
    .head_iy1_i    (h_iy1),
    .head_fx_i     (h_fx),
    .head_fy_i     (h_fy),
    .head_value_i  (h_value),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .noise_value_o (noise_value_o)
  );

  // the back part never pulls from an empty queue
  assert property (@(posedge clk_i) disable iff (!rst_ni) q_pop |-> !q_empty)
    else $error("queue popped while empty");

  // an item held in the front register by a full queue is still offered next cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni) in_stall_o |=> q_push)
    else $error("front item lost while stalled");

  // a full queue stays full until the back part takes an item
  assert property (@(posedge clk_i) disable iff (!rst_ni) q_full && !q_pop |=> q_full)
    else $error("queue occupancy dropped without a pop");

  // a waiting result freezes the back pipeline, so nothing leaves the queue
  assert property (@(posedge clk_i) disable iff (!rst_ni)
                   out_valid_o && out_stall_i |-> !q_pop)
    else $error("queue popped while the result is stalled");

endmodule

[verif/tb_gradient_noise_2d_core.sv]
// tb_gradient_noise_2d_core: self-checking testbench for the 2-D gradient noise core.
// Fills the permutation table, then streams sample and load items against an in-bench
// predictor. Depends on gn2d_pkg and gradient_noise_2d_core.
`timescale 1ns / 1ps

module tb_gradient_noise_2d_core;
  import gn2d_pkg::*;

  localparam int unsigned FRAC     = FRAC_BITS_DEF;
  localparam int unsigned OUT_W    = FRAC + 2;
  localparam longint      ONE      = longint'(1) << FRAC;
  localparam int          HOLD_CYC = 300;    // long receiver hold-off
  localparam int          DRAIN_MAX = 20000; // bound on any wait for results
  localparam int          SETTLE   = 12;     // pipeline depth plus margin

  logic                     clk_i = 1'b0;
  logic                     rst_ni = 1'b0;
  logic                     in_valid_i = 1'b0;
  logic                     in_stall_o;
  logic                     kind_i = KIND_SAMPLE;
  logic [ENTRY_W-1:0]       entry_index_i = '0;
  logic [ENTRY_W-1:0]       entry_value_i = '0;
  logic [COORD_W-1:0]       coord_x_i = '0;
  logic [COORD_W-1:0]       coord_y_i = '0;
  logic                     out_valid_o;
  logic                     out_stall_i = 1'b0;
  logic signed [OUT_W-1:0]  noise_value_o;

  gradient_noise_2d_core u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .kind_i        (kind_i),
    .entry_index_i (entry_index_i),
    .entry_value_i (entry_value_i),
    .coord_x_i     (coord_x_i),
    .coord_y_i     (coord_y_i),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .noise_value_o (noise_value_o)
  );

  always #5 clk_i = ~clk_i;

  // ---------------------------------------------------------------------------
  // Predictor: shadow permutation table plus the fixed-point noise math.
  // ---------------------------------------------------------------------------
  logic [ENTRY_W-1:0]      perm_shadow [256];
  logic signed [OUT_W-1:0] noise_expected [$];
  int                      err_count = 0;
  int                      idle_pct = 0;
  int                      stall_pct = 0;
  logic                    holding = 1'b0;
  event                    hold_go;

  // quintic fade, Q0.F, truncated and capped just below one
  function automatic longint fade_q(longint f);
    longint t2, t3, p, inner, r;
    t2    = (f * f) >>> FRAC;
    t3    = (t2 * f) >>> FRAC;
    p     = (f * (FADE_K15 * ONE - FADE_K6 * f)) >>> FRAC;
    inner = FADE_K10 * ONE - p;
    r     = (t3 * inner) >>> FRAC;
    if (r > ONE - 1) r = ONE - 1;
    return r;
  endfunction

  // arithmetic shift floors toward negative
  function automatic longint blend_q(longint t, longint a, longint b);
    return a + ((t * (b - a)) >>> FRAC);
  endfunction

  function automatic logic [ENTRY_W-1:0] corner_hash(logic [ENTRY_W-1:0] cx,
                                                     logic [ENTRY_W-1:0] cy);
    logic [ENTRY_W-1:0] mid;
    mid = perm_shadow[cx] + cy;  // wraps mod 256
    return perm_shadow[mid];
  endfunction

  function automatic longint grad_dot(logic [ENTRY_W-1:0] h, longint dx, longint dy);
    case (grad_e'(h[2:0]))
      GRAD_PX_PY: return dx + dy;
      GRAD_PX_NY: return dx - dy;
      GRAD_NX_PY: return -dx + dy;
      GRAD_NX_NY: return -dx - dy;
      GRAD_PX:    return dx;
      GRAD_NX:    return -dx;
      GRAD_PY:    return dy;
      default:    return -dy;
    endcase
  endfunction

  function automatic logic signed [OUT_W-1:0] noise_predict(logic [COORD_W-1:0] cx,
                                                            logic [COORD_W-1:0] cy);
    logic [ENTRY_W-1:0] ix0, iy0, ix1, iy1;
    longint             fx, fy, u, v, g00, g10, g01, g11, x1, x2, r;
    ix0 = cx[FRAC +: ENTRY_W];
    iy0 = cy[FRAC +: ENTRY_W];
    ix1 = ix0 + 8'd1;
    iy1 = iy0 + 8'd1;
    fx  = longint'(cx[FRAC-1:0]);
    fy  = longint'(cy[FRAC-1:0]);
    u   = fade_q(fx);
    v   = fade_q(fy);
    g00 = grad_dot(corner_hash(ix0, iy0), fx, fy);
    g10 = grad_dot(corner_hash(ix1, iy0), fx - ONE, fy);
    g01 = grad_dot(corner_hash(ix0, iy1), fx, fy - ONE);
    g11 = grad_dot(corner_hash(ix1, iy1), fx - ONE, fy - ONE);
    x1  = blend_q(u, g00, g10);
    x2  = blend_q(u, g01, g11);
    r   = blend_q(v, x1, x2);
    if (r > 2 * ONE - 1) r = 2 * ONE - 1;
    if (r < -2 * ONE) r = -2 * ONE;
    return r[OUT_W-1:0];
  endfunction

  // ---------------------------------------------------------------------------
  // Receiver side: random stall plus an optional long hold-off.
  // ---------------------------------------------------------------------------
  always @(posedge clk_i) begin
    out_stall_i <= holding || ($urandom_range(99) < stall_pct);
  end

  always begin
    @(hold_go);
    holding <= 1'b1;
    repeat (HOLD_CYC) @(posedge clk_i);
    holding <= 1'b0;
  end

  // result checker: values read here are the ones settled before the edge
  logic signed [OUT_W-1:0] noise_want;
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o === 1'b1 && out_stall_i === 1'b0) begin
      if (noise_expected.size() == 0) begin
        $error("noise_value: unexpected result, actual %0d", noise_value_o);
        err_count++;
      end else begin
        noise_want = noise_expected.pop_front();
        if (noise_value_o !== noise_want) begin
          $error("noise_value: expected %0d, actual %0d", noise_want, noise_value_o);
          err_count++;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Sender side
  // ---------------------------------------------------------------------------
  task automatic send_item(kind_e k, logic [ENTRY_W-1:0] idx, logic [ENTRY_W-1:0] val,
                           logic [COORD_W-1:0] cx, logic [COORD_W-1:0] cy);
    while ($urandom_range(99) < idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i    <= 1'b1;
    kind_i        <= k;
    entry_index_i <= idx;
    entry_value_i <= val;
    coord_x_i     <= cx;
    coord_y_i     <= cy;
    @(posedge clk_i);
    while (in_stall_o !== 1'b0) @(posedge clk_i);
    // accepted at this edge
    if (k == KIND_LOAD) perm_shadow[idx] = val;
    else noise_expected.push_back(noise_predict(cx, cy));
  endtask

  task automatic wait_results_done();
    int waited;
    waited = 0;
    in_valid_i <= 1'b0;
    while (noise_expected.size() != 0 && waited < DRAIN_MAX) begin
      @(posedge clk_i);
      waited++;
    end
  endtask

  // corners of the fraction range and the wrapping integer part show up often
  function automatic logic [COORD_W-1:0] rand_coord();
    logic [COORD_W-1:0] c;
    c = COORD_W'($urandom);
    case ($urandom_range(7))
      0: c[FRAC-1:0] = '0;
      1: c[FRAC-1:0] = '1;
      2: c[COORD_W-1:FRAC] = '1;
      3: c[FRAC-1:0] = FRAC'(1);
      default: ;
    endcase
    return c;
  endfunction

  task automatic send_random(int pct_load);
    if ($urandom_range(99) < pct_load)
      send_item(KIND_LOAD, ENTRY_W'($urandom), ENTRY_W'($urandom),
                COORD_W'($urandom), COORD_W'($urandom));
    else
      send_item(KIND_SAMPLE, ENTRY_W'($urandom), ENTRY_W'($urandom),
                rand_coord(), rand_coord());
  endtask

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // every entry gets a value before the first sample: a shuffled permutation
  task automatic test_table_fill();
    logic [ENTRY_W-1:0] vals [256];
    logic [ENTRY_W-1:0] tmp;
    int                 j;
    idle_pct  = 25;
    stall_pct = 25;
    for (int i = 0; i < 256; i++) vals[i] = ENTRY_W'(i);
    for (int i = 255; i > 0; i--) begin
      j       = $urandom_range(i);
      tmp     = vals[i];
      vals[i] = vals[j];
      vals[j] = tmp;
    end
    for (int i = 0; i < 256; i++)
      send_item(KIND_LOAD, ENTRY_W'(i), vals[i], COORD_W'($urandom), COORD_W'($urandom));
    wait_results_done();
  endtask

  // each gradient on the origin corner, then coordinate extremes
  task automatic test_directed();
    idle_pct  = 0;
    stall_pct = 0;
    // origin corner hash becomes perm[255], steered per gradient below
    send_item(KIND_LOAD, 8'd0, 8'd255, '0, '0);
    for (int g = 0; g < 8; g++) begin
      send_item(KIND_LOAD, 8'd255, ENTRY_W'(g), '0, '0);
      send_item(KIND_SAMPLE, '0, '0, 24'h00_4000, 24'h00_C000);
    end
    send_item(KIND_LOAD, 8'd128, 8'd0, '1, '1);
    send_item(KIND_SAMPLE, '1, '1, 24'h00_0000, 24'h00_0000);
    send_item(KIND_SAMPLE, '0, '0, 24'hFF_FFFF, 24'hFF_FFFF);
    send_item(KIND_SAMPLE, '0, '0, 24'h00_FFFF, 24'hFF_0000);
    send_item(KIND_SAMPLE, '0, '0, 24'hFF_0000, 24'h00_FFFF);
    send_item(KIND_SAMPLE, '0, '0, 24'h00_0001, 24'hFF_FFFE);
    send_item(KIND_SAMPLE, '0, '0, 24'h80_8000, 24'h7F_7FFF);
    wait_results_done();
  endtask

  task automatic test_random_stream(int n, int idle, int stall);
    idle_pct  = idle;
    stall_pct = stall;
    repeat (n) send_random(10);
    wait_results_done();
  endtask

  // receiver holds off while the sender keeps offering: queue fills, input stalls
  task automatic test_backpressure();
    idle_pct  = 0;
    stall_pct = 0;
    -> hold_go;
    repeat (60) send_random(5);
    wait_results_done();
  endtask

  // sender pauses mid-stream until every result is back
  task automatic test_pause_drain();
    idle_pct  = 0;
    stall_pct = 25;
    repeat (30) send_random(10);
    wait_results_done();
    repeat (30) send_random(10);
    wait_results_done();
  endtask

  initial begin
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_table_fill();
    test_directed();
    test_random_stream(350, 0, 0);
    test_random_stream(350, 49, 0);
    test_random_stream(350, 0, 49);
    test_random_stream(350, 25, 25);
    test_backpressure();
    test_pause_drain();

    wait_results_done();
    repeat (SETTLE) @(posedge clk_i);
    if (noise_expected.size() != 0) begin
      $error("noise_value: %0d expected results never arrived", noise_expected.size());
      err_count++;
    end
    if (err_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

  // run limit, far above the slowest legal run
  initial begin
    #2000000;
    $display("DONE: errors detected");
    $finish;
  end

endmodule

[files.f]
sv/gn2d_pkg.sv
sv/gn2d_front.sv
sv/gn2d_queue.sv
sv/gn2d_back.sv
sv/gradient_noise_2d_core.sv
verif/tb_gradient_noise_2d_core.sv
